@@ rtl/assert_macros.svh @@
// Assertion macros used by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge outside of reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// The condition must never be true at a rising clock edge outside of reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

@@ rtl/b64_pkg.sv @@
package b64_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned SextW  = 6;
  localparam int unsigned GroupW = 24;
  localparam int unsigned MaxRes = 4;

  localparam logic [ByteW-1:0] CharUpperA = 8'h41;
  localparam logic [ByteW-1:0] CharLowerA = 8'h61;
  localparam logic [ByteW-1:0] CharZero   = 8'h30;
  localparam logic [ByteW-1:0] CharPlus   = 8'h2B;
  localparam logic [ByteW-1:0] CharSlash  = 8'h2F;
  localparam logic [ByteW-1:0] CharPad    = 8'h3D;

  localparam logic [SextW:0] InvalidCode = 7'd64;

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [MaxRes-1:0][ByteW-1:0] res_bytes_t;

  function automatic byte_t b64_char(logic [SextW-1:0] v);
    byte_t c;
    if (v < 6'd26) begin
      c = CharUpperA + {2'b00, v};
    end else if (v < 6'd52) begin
      c = CharLowerA + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = CharZero + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = CharPlus;
    end else begin
      c = CharSlash;
    end
    return c;
  endfunction

  function automatic logic [SextW:0] b64_value(byte_t c);
    logic [SextW:0] v;
    if (c inside {[8'h41:8'h5A]}) begin
      v = {1'b0, 6'(c - CharUpperA)};
    end else if (c inside {[8'h61:8'h7A]}) begin
      v = {1'b0, 6'(c - 8'h47)};
    end else if (c inside {[8'h30:8'h39]}) begin
      v = {1'b0, 6'(c + 8'd4)};
    end else if (c == CharPlus) begin
      v = 7'd62;
    end else if (c == CharSlash) begin
      v = 7'd63;
    end else begin
      v = InvalidCode;
    end
    return v;
  endfunction

endpackage

@@ rtl/b64_in_if.sv @@
interface b64_in_if;
  logic            valid;
  logic            ready;
  b64_pkg::byte_t  data_byte;
  logic            last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

@@ rtl/b64_out_if.sv @@
interface b64_out_if;
  logic            valid;
  logic            ready;
  b64_pkg::byte_t  out_byte;
  logic            run_last;
  logic            message_end;

  modport source (output valid, output out_byte, output run_last, output message_end,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input message_end,
                  output ready);
endinterface

@@ rtl/base64_codec.sv @@
// Channel   Direction  Payload
// in_i      sink       data_byte[7:0], last_byte
// out_o     source     out_byte[7:0], run_last, message_end
// cfg       write      cfg_we_i, cfg_wdata_i (decode_mode)
//
// One input item is taken per cycle while the result buffer is free.
// An item gives zero to four results, sent one per cycle from the buffer
// while out_o is ready.
// A new item is taken in the cycle that the last buffered result transfers.
// Reset clears the group state, the buffer valid flag and decode_mode; stalls on
// out_o hold the buffer and stall in_i.
`include "assert_macros.svh"

module base64_codec (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  b64_in_if.sink    in_i,
  b64_out_if.source out_o
);

  logic                          mode_q;
  logic [b64_pkg::GroupW-1:0]    gb_q, gb_d;
  logic [1:0]                    gc_q, gc_d;
  logic                          stop_q, stop_d;

  logic                          buf_v_q;
  logic [1:0]                    idx_q, last_q;
  b64_pkg::res_bytes_t           bytes_q;
  logic                          end_q;

  logic                          in_fire, out_fire;
  b64_pkg::res_bytes_t           res;
  logic [2:0]                    res_n;

  logic [2:0]                    enc_cnt;
  logic [b64_pkg::GroupW-1:0]    enc_bits, pad_bits;
  logic [b64_pkg::SextW:0]       val;
  logic                          val_ok;
  logic [b64_pkg::GroupW-1:0]    dec_bits;
  logic [2:0]                    dec_cnt;

  assign in_fire  = in_i.valid & in_i.ready;
  assign out_fire = out_o.valid & out_o.ready;

  assign in_i.ready        = !buf_v_q || (out_o.ready && (idx_q == last_q));
  assign out_o.valid       = buf_v_q;
  assign out_o.out_byte    = bytes_q[idx_q];
  assign out_o.run_last    = (idx_q == last_q);
  assign out_o.message_end = end_q;

  always_comb begin
    enc_cnt  = {1'b0, gc_q} + 3'd1;
    enc_bits = {gb_q[15:0], in_i.data_byte};
    pad_bits = (enc_cnt == 3'd1) ? {in_i.data_byte, 16'h0000}
                                 : {gb_q[7:0], in_i.data_byte, 8'h00};
    val      = b64_pkg::b64_value(in_i.data_byte);
    val_ok   = !val[b64_pkg::SextW];
    dec_bits = val_ok ? {gb_q[17:0], val[b64_pkg::SextW-1:0]} : gb_q;
    dec_cnt  = val_ok ? ({1'b0, gc_q} + 3'd1) : {1'b0, gc_q};

    res    = '0;
    res_n  = 3'd0;
    gb_d   = gb_q;
    gc_d   = gc_q;
    stop_d = stop_q;

    if (!mode_q) begin
      if (enc_cnt == 3'd3) begin
        res[0] = b64_pkg::b64_char(enc_bits[23:18]);
        res[1] = b64_pkg::b64_char(enc_bits[17:12]);
        res[2] = b64_pkg::b64_char(enc_bits[11:6]);
        res[3] = b64_pkg::b64_char(enc_bits[5:0]);
        res_n  = 3'd4;
        gb_d   = '0;
        gc_d   = 2'd0;
      end else begin
        if (in_i.last_byte) begin
          res[0] = b64_pkg::b64_char(pad_bits[23:18]);
          res[1] = b64_pkg::b64_char(pad_bits[17:12]);
          res[2] = (enc_cnt == 3'd2) ? b64_pkg::b64_char(pad_bits[11:6])
                                     : b64_pkg::CharPad;
          res[3] = b64_pkg::CharPad;
          res_n  = 3'd4;
        end
        gb_d = enc_bits;
        gc_d = enc_cnt[1:0];
      end
    end else if (!stop_q) begin
      if (dec_cnt == 3'd4) begin
        res[0] = dec_bits[23:16];
        res[1] = dec_bits[15:8];
        res[2] = dec_bits[7:0];
        res_n  = 3'd3;
        gb_d   = '0;
        gc_d   = 2'd0;
      end else begin
        if ((!val_ok || in_i.last_byte) && (dec_cnt == 3'd2)) begin
          res[0] = dec_bits[11:4];
          res_n  = 3'd1;
        end else if ((!val_ok || in_i.last_byte) && (dec_cnt == 3'd3)) begin
          res[0] = dec_bits[17:10];
          res[1] = dec_bits[9:2];
          res_n  = 3'd2;
        end
        gb_d = val_ok ? dec_bits : '0;
        gc_d = val_ok ? dec_cnt[1:0] : 2'd0;
      end
      stop_d = !val_ok;
    end

    if (in_i.last_byte) begin
      gb_d   = '0;
      gc_d   = 2'd0;
      stop_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      gb_q   <= '0;
      gc_q   <= 2'd0;
      stop_q <= 1'b0;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
      gb_q   <= '0;
      gc_q   <= 2'd0;
      stop_q <= 1'b0;
    end else if (in_fire) begin
      gb_q   <= gb_d;
      gc_q   <= gc_d;
      stop_q <= stop_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_v_q <= 1'b0;
      idx_q   <= 2'd0;
      last_q  <= 2'd0;
    end else if (in_fire && (res_n != 3'd0)) begin
      buf_v_q <= 1'b1;
      idx_q   <= 2'd0;
      last_q  <= 2'(res_n - 3'd1);
    end else if (out_fire) begin
      if (idx_q == last_q) begin
        buf_v_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && (res_n != 3'd0)) begin
      bytes_q <= res;
      end_q   <= in_i.last_byte;
    end
  end

  `ASSERT_CLK(a_idx_in_range, clk_i, rst_ni, buf_v_q |-> (idx_q <= last_q))
  `ASSERT_CLK(a_msg_end_clears, clk_i, rst_ni,
              (in_fire && in_i.last_byte) |=> ((gc_q == 2'd0) && !stop_q))
  `ASSERT_NEVER(a_enc_count, clk_i, rst_ni, !mode_q && (gc_q == 2'd3))
  `ASSERT_CLK(a_run_continues, clk_i, rst_ni,
              (out_fire && !out_o.run_last) |=> out_o.valid)

endmodule
